// ----- hw/rtl/fpg2p_pkg.sv -----
// shared types and constants of the flip/pic grid-to-particle transfer block
package fpg2p_pkg;

	localparam int GRID_COLUMNS_DEF  = 8;
	localparam int GRID_ROWS_DEF     = 8;
	localparam int FRACTION_BITS_DEF = 10;

	localparam int VEL_W   = 16;
	localparam int POS_W   = 16;
	localparam int INDEX_W = 12;
	localparam int RATIO_W = 9;

	localparam logic [RATIO_W-1:0] RATIO_RESET = 9'd230;
	localparam logic [RATIO_W-1:0] RATIO_ONE   = 9'd256;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] CORNER_LAST = 2'd3;
	localparam logic [1:0] DRAIN_LAST  = 2'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADDR,
		S_DRAIN,
		S_FLIP,
		S_MUL,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic       write_point;
		logic       load_query;
		logic       issue;
		logic [1:0] corner;
		logic       flip_step;
		logic       mul_step;
		logic       load_out;
	} cmd_t;

endpackage

// ----- hw/rtl/fpg2p_if.sv -----
// handshake channels of the transfer block: items in, results out, ratio writes
interface fpg2p_item_if;
	logic                                    valid;
	logic                                    ready;
	logic                                    opcode;
	logic [fpg2p_pkg::INDEX_W-1:0]           point_index;
	logic signed [fpg2p_pkg::VEL_W-1:0]      grid_horizontal;
	logic signed [fpg2p_pkg::VEL_W-1:0]      grid_vertical;
	logic signed [fpg2p_pkg::VEL_W-1:0]      prior_horizontal;
	logic signed [fpg2p_pkg::VEL_W-1:0]      prior_vertical;
	logic [fpg2p_pkg::POS_W-1:0]             particle_x;
	logic [fpg2p_pkg::POS_W-1:0]             particle_y;
	logic signed [fpg2p_pkg::VEL_W-1:0]      particle_vx;
	logic signed [fpg2p_pkg::VEL_W-1:0]      particle_vy;

	modport source (
		output valid, opcode, point_index, grid_horizontal, grid_vertical,
			prior_horizontal, prior_vertical, particle_x, particle_y,
			particle_vx, particle_vy,
		input  ready
	);
	modport sink (
		input  valid, opcode, point_index, grid_horizontal, grid_vertical,
			prior_horizontal, prior_vertical, particle_x, particle_y,
			particle_vx, particle_vy,
		output ready
	);
endinterface

interface fpg2p_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [fpg2p_pkg::VEL_W-1:0] new_vx;
	logic signed [fpg2p_pkg::VEL_W-1:0] new_vy;

	modport source (output valid, new_vx, new_vy, input ready);
	modport sink (input valid, new_vx, new_vy, output ready);
endinterface

interface fpg2p_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [fpg2p_pkg::RATIO_W-1:0]    blend_ratio;

	modport source (output valid, blend_ratio, input ready);
	modport sink (input valid, blend_ratio, output ready);
endinterface

// ----- hw/rtl/fpg2p_ctrl.sv -----
// sequencer of the transfer block: handshakes, corner walk and blend steps
module fpg2p_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_opcode,
	output logic              item_ready,
	input  logic              result_ready,
	output logic              result_valid,
	output fpg2p_pkg::cmd_t   cmd
);

	fpg2p_pkg::state_t state_q, state_d;
	logic [1:0]        cnt_q;
	logic              result_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fpg2p_pkg::S_IDLE: begin
				if (item_valid && item_opcode == fpg2p_pkg::OP_QUERY) begin
					state_d = fpg2p_pkg::S_ADDR;
				end
			end
			fpg2p_pkg::S_ADDR: begin
				if (cnt_q == fpg2p_pkg::CORNER_LAST) begin
					state_d = fpg2p_pkg::S_DRAIN;
				end
			end
			fpg2p_pkg::S_DRAIN: begin
				if (cnt_q == fpg2p_pkg::DRAIN_LAST) begin
					state_d = fpg2p_pkg::S_FLIP;
				end
			end
			fpg2p_pkg::S_FLIP: begin
				state_d = fpg2p_pkg::S_MUL;
			end
			fpg2p_pkg::S_MUL: begin
				state_d = fpg2p_pkg::S_FINISH;
			end
			fpg2p_pkg::S_FINISH: begin
				if (!result_valid_q || result_ready) begin
					state_d = fpg2p_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fpg2p_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		item_ready      = (state_q == fpg2p_pkg::S_IDLE);
		cmd.write_point = item_ready && item_valid && item_opcode == fpg2p_pkg::OP_WRITE;
		cmd.load_query  = item_ready && item_valid && item_opcode == fpg2p_pkg::OP_QUERY;
		cmd.issue       = (state_q == fpg2p_pkg::S_ADDR);
		cmd.corner      = cnt_q;
		cmd.flip_step   = (state_q == fpg2p_pkg::S_FLIP);
		cmd.mul_step    = (state_q == fpg2p_pkg::S_MUL);
		cmd.load_out    = (state_q == fpg2p_pkg::S_FINISH)
			&& (!result_valid_q || result_ready);
	end

	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= fpg2p_pkg::S_IDLE;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fpg2p_pkg::S_ADDR || state_q == fpg2p_pkg::S_DRAIN) begin
				cnt_q <= cnt_q + 2'd1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hw/rtl/fpg2p_dp.sv -----
// datapath of the transfer block: grid memories, weights, accumulators, blend
module fpg2p_dp #(
	parameter int GRID_COLUMNS  = fpg2p_pkg::GRID_COLUMNS_DEF,
	parameter int GRID_ROWS     = fpg2p_pkg::GRID_ROWS_DEF,
	parameter int FRACTION_BITS = fpg2p_pkg::FRACTION_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  fpg2p_pkg::cmd_t                        cmd,
	input  logic                                   cfg_we,
	input  logic [fpg2p_pkg::RATIO_W-1:0]          cfg_ratio,
	input  logic [fpg2p_pkg::INDEX_W-1:0]          point_index,
	input  logic signed [fpg2p_pkg::VEL_W-1:0]     grid_horizontal,
	input  logic signed [fpg2p_pkg::VEL_W-1:0]     grid_vertical,
	input  logic signed [fpg2p_pkg::VEL_W-1:0]     prior_horizontal,
	input  logic signed [fpg2p_pkg::VEL_W-1:0]     prior_vertical,
	input  logic [fpg2p_pkg::POS_W-1:0]            particle_x,
	input  logic [fpg2p_pkg::POS_W-1:0]            particle_y,
	input  logic signed [fpg2p_pkg::VEL_W-1:0]     particle_vx,
	input  logic signed [fpg2p_pkg::VEL_W-1:0]     particle_vy,
	output logic signed [fpg2p_pkg::VEL_W-1:0]     new_vx,
	output logic signed [fpg2p_pkg::VEL_W-1:0]     new_vy
);

	localparam int F      = FRACTION_BITS;
	localparam int POINTS = GRID_COLUMNS * GRID_ROWS;
	localparam int AW     = $clog2(POINTS);
	localparam int CW     = $clog2(GRID_COLUMNS);
	localparam int RW     = $clog2(GRID_ROWS);
	localparam int VW     = fpg2p_pkg::VEL_W;
	localparam int PW     = fpg2p_pkg::POS_W;
	localparam int FW     = F + 1;
	localparam int WW     = 2 * F + 2;
	localparam int PV_W   = WW + 1 + VW;
	localparam int PD_W   = WW + 1 + VW + 1;
	localparam int AP_W   = PV_W + 2;
	localparam int AD_W   = PD_W + 2;
	localparam int FL_W   = AD_W + 2;
	localparam int TP_W   = AP_W + 10;
	localparam int TF_W   = FL_W + 10;
	localparam int TOT_W  = TF_W + 1;
	localparam int SH     = 2 * F + 8;
	localparam int RES_W  = TOT_W - SH;

	localparam logic [PW-1:0] HALF    = PW'(2 ** (F - 1));
	localparam logic [FW-1:0] ONE     = FW'(2 ** F);
	localparam logic [PW-1:0] COL_LIM = PW'(GRID_COLUMNS - 2);
	localparam logic [PW-1:0] ROW_LIM = PW'(GRID_ROWS - 2);
	localparam logic signed [TOT_W-1:0] ROUND  = TOT_W'(1) << (SH - 1);
	localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(32767);
	localparam logic signed [RES_W-1:0] SAT_LO = -RES_W'(32768);

	typedef struct packed {
		logic [PW-1:0] base;
		logic [FW-1:0] frac;
	} loc_t;

	// corner cell and clamped offset along one axis
	function automatic loc_t locate(input logic [PW-1:0] pos, input logic shift,
		input logic [PW-1:0] lim);
		logic [PW-1:0] p;
		logic [PW-1:0] c;
		logic [PW-1:0] rem;
		loc_t          r;
		p   = shift ? ((pos < HALF) ? '0 : pos - HALF) : pos;
		c   = p >> F;
		rem = '0;
		if (c > lim) begin
			c      = lim;
			rem    = p - (lim << F);
			r.frac = (rem > PW'(ONE)) ? ONE : rem[FW-1:0];
		end else begin
			r.frac = {1'b0, p[F-1:0]};
		end
		r.base = c;
		return r;
	endfunction

	// round, scale down and saturate one blended sum
	function automatic logic signed [VW-1:0] finish_val(
		input logic signed [TP_W-1:0] tp, input logic signed [TF_W-1:0] tf);
		logic signed [TOT_W-1:0] total;
		logic signed [RES_W-1:0] res;
		total = TOT_W'(tp) + TOT_W'(tf) + ROUND;
		res   = total[TOT_W-1:SH];
		if (res > SAT_HI) begin
			return 16'sh7fff;
		end else if (res < SAT_LO) begin
			return -16'sh8000;
		end
		return res[VW-1:0];
	endfunction

	logic [RW-1:0]              unused_rw;
	loc_t                       loc_hx, loc_hy, loc_vx, loc_vy;
	logic [fpg2p_pkg::RATIO_W-1:0] blend_ratio_q, ratio_q;
	logic [CW-1:0]              hcx_q, vcx_q;
	logic [RW-1:0]              hcy_q, vcy_q;
	logic [FW-1:0]              hfx_q, hfy_q, vfx_q, vfy_q;
	logic signed [VW-1:0]       pvx_q, pvy_q;

	logic                       xi, yi;
	logic [CW-1:0]              hx, vx;
	logic [RW-1:0]              hy, vy;
	logic [AW-1:0]              addr_h, addr_v, waddr;
	logic                       wr_ok;
	logic [FW-1:0]              wxh, wyh, wxv, wyv;
	logic [WW-1:0]              w_h, w_v;

	logic [2*VW-1:0]            mem_h [POINTS];
	logic [2*VW-1:0]            mem_v [POINTS];
	logic [2*VW-1:0]            rd_h_s1, rd_v_s1;
	logic [WW-1:0]              w_h_s1, w_v_s1;
	logic                       v_s1, v_s2;

	logic signed [VW:0]         dh, dv;
	logic signed [PV_W-1:0]     pv_h_s2, pv_v_s2;
	logic signed [PD_W-1:0]     pd_h_s2, pd_v_s2;
	logic signed [AP_W-1:0]     acc_ph_q, acc_pv_q;
	logic signed [AD_W-1:0]     acc_dh_q, acc_dv_q;
	logic signed [FL_W-1:0]     flip_h_q, flip_v_q;
	logic signed [TP_W-1:0]     tp_h_q, tp_v_q;
	logic signed [TF_W-1:0]     tf_h_q, tf_v_q;
	logic signed [9:0]          pic_wt, flip_wt;
	logic signed [VW-1:0]       new_vx_q, new_vy_q;

	assign unused_rw = '0;

	// horizontal samples sit at half-row offsets, vertical ones at half-column
	assign loc_hx = locate(particle_x, 1'b0, COL_LIM);
	assign loc_hy = locate(particle_y, 1'b1, ROW_LIM);
	assign loc_vx = locate(particle_x, 1'b1, COL_LIM);
	assign loc_vy = locate(particle_y, 1'b0, ROW_LIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_ratio_q <= fpg2p_pkg::RATIO_RESET;
		end else if (cfg_we) begin
			blend_ratio_q <= cfg_ratio;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			hcx_q   <= loc_hx.base[CW-1:0];
			hcy_q   <= loc_hy.base[RW-1:0] | unused_rw;
			hfx_q   <= loc_hx.frac;
			hfy_q   <= loc_hy.frac;
			vcx_q   <= loc_vx.base[CW-1:0];
			vcy_q   <= loc_vy.base[RW-1:0];
			vfx_q   <= loc_vx.frac;
			vfy_q   <= loc_vy.frac;
			pvx_q   <= particle_vx;
			pvy_q   <= particle_vy;
			ratio_q <= (blend_ratio_q > fpg2p_pkg::RATIO_ONE) ? fpg2p_pkg::RATIO_ONE
				: blend_ratio_q;
		end
	end

	// corner order: (x,y), (x+1,y), (x+1,y+1), (x,y+1)
	always_comb begin
		xi     = cmd.corner[0] ^ cmd.corner[1];
		yi     = cmd.corner[1];
		hx     = hcx_q + CW'(xi);
		hy     = hcy_q + RW'(yi);
		vx     = vcx_q + CW'(xi);
		vy     = vcy_q + RW'(yi);
		addr_h = AW'(hx) * AW'(GRID_ROWS) + AW'(hy);
		addr_v = AW'(vx) * AW'(GRID_ROWS) + AW'(vy);
		wxh    = xi ? hfx_q : ONE - hfx_q;
		wyh    = yi ? hfy_q : ONE - hfy_q;
		wxv    = xi ? vfx_q : ONE - vfx_q;
		wyv    = yi ? vfy_q : ONE - vfy_q;
		w_h    = WW'(wxh) * WW'(wyh);
		w_v    = WW'(wxv) * WW'(wyv);
		waddr  = point_index[AW-1:0];
		wr_ok  = {1'b0, point_index} < (fpg2p_pkg::INDEX_W + 1)'(POINTS);
	end

	// grid memories, entry holds {now, before}
	always_ff @(posedge clk) begin
		if (cmd.write_point && wr_ok) begin
			mem_h[waddr] <= {grid_horizontal, prior_horizontal};
			mem_v[waddr] <= {grid_vertical, prior_vertical};
		end
		if (cmd.issue) begin
			rd_h_s1 <= mem_h[addr_h];
			rd_v_s1 <= mem_v[addr_v];
			w_h_s1  <= w_h;
			w_v_s1  <= w_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	assign dh = $signed({rd_h_s1[2*VW-1], rd_h_s1[2*VW-1:VW]})
		- $signed({rd_h_s1[VW-1], rd_h_s1[VW-1:0]});
	assign dv = $signed({rd_v_s1[2*VW-1], rd_v_s1[2*VW-1:VW]})
		- $signed({rd_v_s1[VW-1], rd_v_s1[VW-1:0]});

	always_ff @(posedge clk) begin
		if (v_s1) begin
			pv_h_s2 <= $signed({1'b0, w_h_s1}) * $signed(rd_h_s1[2*VW-1:VW]);
			pv_v_s2 <= $signed({1'b0, w_v_s1}) * $signed(rd_v_s1[2*VW-1:VW]);
			pd_h_s2 <= $signed({1'b0, w_h_s1}) * dh;
			pd_v_s2 <= $signed({1'b0, w_v_s1}) * dv;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			acc_ph_q <= '0;
			acc_pv_q <= '0;
			acc_dh_q <= '0;
			acc_dv_q <= '0;
		end else if (v_s2) begin
			acc_ph_q <= acc_ph_q + AP_W'(pv_h_s2);
			acc_pv_q <= acc_pv_q + AP_W'(pv_v_s2);
			acc_dh_q <= acc_dh_q + AD_W'(pd_h_s2);
			acc_dv_q <= acc_dv_q + AD_W'(pd_v_s2);
		end
	end

	assign pic_wt  = $signed({1'b0, fpg2p_pkg::RATIO_ONE - ratio_q});
	assign flip_wt = $signed({1'b0, ratio_q});

	always_ff @(posedge clk) begin
		if (cmd.flip_step) begin
			flip_h_q <= (FL_W'(pvx_q) <<< (2 * F)) + FL_W'(acc_dh_q);
			flip_v_q <= (FL_W'(pvy_q) <<< (2 * F)) + FL_W'(acc_dv_q);
		end
		if (cmd.mul_step) begin
			tp_h_q <= pic_wt * acc_ph_q;
			tp_v_q <= pic_wt * acc_pv_q;
			tf_h_q <= flip_wt * flip_h_q;
			tf_v_q <= flip_wt * flip_v_q;
		end
		if (cmd.load_out) begin
			new_vx_q <= finish_val(tp_h_q, tf_h_q);
			new_vy_q <= finish_val(tp_v_q, tf_v_q);
		end
	end

	assign new_vx = new_vx_q;
	assign new_vy = new_vy_q;

endmodule

// ----- hw/rtl/flip_pic_grid_to_particle.sv -----
// top level of the flip/pic grid-to-particle velocity transfer block
// A grid write beat is taken in any idle cycle and leaves the block idle,
// so writes stream back to back. A query beat is taken in an idle cycle;
// the sequencer then walks the four corners of the horizontal and vertical
// cells in parallel (one read per cycle on each of the two grid memories),
// the drain states let the weight and product stages drain into the
// accumulators, then the flip, multiply and finish states form the flip
// term, the blend products, and the rounded and saturated result, which is
// loaded into the output register. The next beat is taken as soon as that
// result sits in the output register, even while the consumer has not yet
// taken it; if the previous result is still waiting, the finishing step
// holds until it goes. Grid memory contents are undefined until written
// and need no clearing after reset. The blend ratio is to be written by the
// user through its own channel only while the block is idle; the block
// itself does not enforce this. Values above 256 act as 256.
module flip_pic_grid_to_particle #(
	parameter int GRID_COLUMNS  = fpg2p_pkg::GRID_COLUMNS_DEF,
	parameter int GRID_ROWS     = fpg2p_pkg::GRID_ROWS_DEF,
	parameter int FRACTION_BITS = fpg2p_pkg::FRACTION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fpg2p_item_if.sink            item,
	fpg2p_result_if.source        result,
	fpg2p_cfg_if.sink             cfg
);

	fpg2p_pkg::cmd_t cmd;

	// ratio register is always writable
	assign cfg.ready = 1'b1;

	// sequencer: owns the item and result handshakes and steps the datapath
	fpg2p_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_opcode  (item.opcode),
		.item_ready   (item.ready),
		.result_ready (result.ready),
		.result_valid (result.valid),
		.cmd          (cmd)
	);

	// grid memories, bilinear weights, accumulators and blend
	fpg2p_dp #(
		.GRID_COLUMNS  (GRID_COLUMNS),
		.GRID_ROWS     (GRID_ROWS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_we           (cfg.valid),
		.cfg_ratio        (cfg.blend_ratio),
		.point_index      (item.point_index),
		.grid_horizontal  (item.grid_horizontal),
		.grid_vertical    (item.grid_vertical),
		.prior_horizontal (item.prior_horizontal),
		.prior_vertical   (item.prior_vertical),
		.particle_x       (item.particle_x),
		.particle_y       (item.particle_y),
		.particle_vx      (item.particle_vx),
		.particle_vy      (item.particle_vy),
		.new_vx           (result.new_vx),
		.new_vy           (result.new_vy)
	);

endmodule
